### sv/audio_level_meter_core_defines.svh
// Assertion macros for the audio level meter core.
// Included by the modules that check their own control logic; expects clk and rst_n.
`ifndef AUDIO_LEVEL_METER_CORE_DEFINES_SVH
`define AUDIO_LEVEL_METER_CORE_DEFINES_SVH

// same-cycle implication, inactive during reset
`define ALM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive during reset
`define ALM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/alm_pkg.sv
// Shared types and constants of the audio level meter core.
// No dependencies; imported by every module of the block but alm_queue.
`timescale 1ns / 1ps

package alm_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int MAG_W      = 23;
    localparam int COEF_W     = 16;
    localparam int CFG_COEF_W = 17;
    localparam int CH_W       = 4;
    localparam int HOLD_W     = 20;
    localparam int FRAME_W    = 13;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [MAG_W-1:0]      MAG_MAX   = {MAG_W{1'b1}};
    localparam logic [FRAME_W-1:0]    FRAME_MAX = {FRAME_W{1'b1}};
    localparam logic [CFG_COEF_W-1:0] COEF_ONE  = 17'h10000;
    localparam logic [COEF_W-1:0]     DECAY_Q16 = 16'd60293;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES    = 3'd4;

    typedef struct packed {
        logic [CH_W-1:0]       channel_count;
        logic [MAG_W-1:0]      clip_threshold;
        logic [CFG_COEF_W-1:0] attack_coef;
        logic [CFG_COEF_W-1:0] release_coef;
        logic [HOLD_W-1:0]     hold_frames;
    } alm_cfg_t;

    typedef struct packed {
        logic [MAG_W-1:0]   peak;
        logic [MAG_W-1:0]   left;
        logic [MAG_W-1:0]   right;
        logic [FRAME_W-1:0] frames;
        logic               clip;
    } alm_summary_t;

endpackage

### sv/alm_front.sv
// Front end: per-sample magnitude, peaks, sum of squares, frame and clip tracking.
// Pushes one block summary per block end. Depends on alm_pkg.
`timescale 1ns / 1ps

module alm_front #(
    parameter int MAX_BLOCK_SAMPLES = 4096,
    parameter int CNT_W             = 13,
    parameter int SUM_W             = 59
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  alm_pkg::alm_cfg_t             cfg,
    input  logic signed [23:0]            sample,
    input  logic                          last_of_block,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          q_full,
    output logic                          q_push,
    output alm_pkg::alm_summary_t         q_summary,
    output logic [SUM_W-1:0]              q_sum,
    output logic [CNT_W-1:0]              q_count
);
    import alm_pkg::*;

    logic [MAG_W-1:0]   peak_reg, peak_next;
    logic [MAG_W-1:0]   left_reg, left_next;
    logic [MAG_W-1:0]   right_reg, right_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [2:0]         pos_reg, pos_next;
    logic               clip_reg, clip_next;

    logic [CH_W-1:0]     cnt_eff;
    logic [SAMPLE_W-1:0] mag_wide;
    logic [MAG_W-1:0]    mag;
    logic [SQ_W-1:0]     sq;
    logic [CH_W-1:0]     pos_inc;
    logic                multi;
    logic                room;
    logic                accept;

    assign in_ready = ~q_full;
    assign accept   = in_valid & in_ready;
    assign q_push   = accept & last_of_block;

    always_comb
    begin
        if (cfg.channel_count == 4'd0)
        begin
            cnt_eff = 4'd1;
        end
        else if (cfg.channel_count > 4'd8)
        begin
            cnt_eff = 4'd8;
        end
        else
        begin
            cnt_eff = cfg.channel_count;
        end
        multi    = (cnt_eff >= 4'd2);
        mag_wide = sample[SAMPLE_W-1] ? (~$unsigned(sample) + 24'd1) : $unsigned(sample);
        mag      = mag_wide[SAMPLE_W-1] ? MAG_MAX : mag_wide[MAG_W-1:0];
        sq       = SQ_W'(mag) * SQ_W'(mag);
        room     = (count_reg < CNT_W'(MAX_BLOCK_SAMPLES));

        peak_next  = (mag > peak_reg) ? mag : peak_reg;
        left_next  = (multi && pos_reg == 3'd0 && mag > left_reg) ? mag : left_reg;
        right_next = (multi && pos_reg == 3'd1 && mag > right_reg) ? mag : right_reg;
        sum_next   = room ? (sum_reg + SUM_W'(sq)) : sum_reg;
        count_next = room ? (count_reg + CNT_W'(1)) : count_reg;
        frame_next = (pos_reg == 3'd0 && frame_reg < FRAME_MAX) ?
                     (frame_reg + FRAME_W'(1)) : frame_reg;
        pos_inc    = {1'b0, pos_reg} + 4'd1;
        pos_next   = (pos_inc >= cnt_eff) ? 3'd0 : pos_inc[2:0];
        clip_next  = clip_reg | (mag >= cfg.clip_threshold);

        q_summary.peak   = peak_next;
        q_summary.left   = multi ? left_next : peak_next;
        q_summary.right  = multi ? right_next : peak_next;
        q_summary.frames = frame_next;
        q_summary.clip   = clip_next;
        q_sum            = sum_next;
        q_count          = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            frame_reg <= '0;
            pos_reg   <= '0;
            clip_reg  <= 1'b0;
        end
        else if (accept)
        begin
            clip_reg <= clip_next;
            if (last_of_block)
            begin
                peak_reg  <= '0;
                left_reg  <= '0;
                right_reg <= '0;
                sum_reg   <= '0;
                count_reg <= '0;
                frame_reg <= '0;
                pos_reg   <= '0;
            end
            else
            begin
                peak_reg  <= peak_next;
                left_reg  <= left_next;
                right_reg <= right_next;
                sum_reg   <= sum_next;
                count_reg <= count_next;
                frame_reg <= frame_next;
                pos_reg   <= pos_next;
            end
        end
    end

endmodule

### sv/alm_queue.sv
// Two-entry word queue between the front end and the back end.
// Generic width; no package dependencies.
`timescale 1ns / 1ps

module alm_queue #(
    parameter int WIDTH = 130
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             not_empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### sv/alm_back.sv
// Back end: serial divide and square root for RMS, envelope and peak hold update.
// Holds the result word until taken. Depends on alm_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "audio_level_meter_core_defines.svh"

module alm_back #(
    parameter int CNT_W = 13,
    parameter int SUM_W = 59
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  alm_pkg::alm_cfg_t     cfg,
    input  logic                  q_valid,
    input  alm_pkg::alm_summary_t q_summary,
    input  logic [SUM_W-1:0]      q_sum,
    input  logic [CNT_W-1:0]      q_count,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [22:0]           envelope_level,
    output logic [22:0]           rms_level,
    output logic [22:0]           left_peak,
    output logic [22:0]           right_peak,
    output logic [22:0]           held_peak,
    output logic                  clip_seen
);
    import alm_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam int EPROD_W = MAG_W + CFG_COEF_W;
    localparam int DPROD_W = MAG_W + COEF_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SQRT = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_EMIT = 5'b10000
    } alm_state_t;

    alm_state_t          state_reg, state_next;
    alm_summary_t        summ_reg, summ_next;
    logic [SUM_W-1:0]    dq_reg, dq_next;
    logic [CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SQ_W-1:0]     rad_reg, rad_next;
    logic [MAG_W:0]      srem_reg, srem_next;
    logic [MAG_W-1:0]    root_reg, root_next;
    logic [EPROD_W-1:0]  eprod_reg, eprod_next;
    logic [DPROD_W-1:0]  dprod_reg, dprod_next;
    logic                up_reg, up_next;
    logic [MAG_W-1:0]    envelope_reg, envelope_next;
    logic [MAG_W-1:0]    hold_reg, hold_next;
    logic [HOLD_W-1:0]   timer_reg, timer_next;
    logic                out_valid_reg, out_valid_next;
    logic [MAG_W-1:0]    env_out_reg, env_out_next;
    logic [MAG_W-1:0]    rms_out_reg, rms_out_next;
    logic [MAG_W-1:0]    left_out_reg, left_out_next;
    logic [MAG_W-1:0]    right_out_reg, right_out_next;
    logic [MAG_W-1:0]    held_out_reg, held_out_next;
    logic                clip_out_reg, clip_out_next;

    logic [CNT_W:0]        div_shift;
    logic                  div_ge;
    logic [MAG_W+2:0]      sq_cand;
    logic [MAG_W+2:0]      sq_trial;
    logic                  sq_ge;
    logic [MAG_W-1:0]      diff;
    logic [CFG_COEF_W-1:0] coef;
    logic [MAG_W-1:0]      env_step;
    logic [MAG_W-1:0]      decayed;
    logic [HOLD_W-1:0]     timer_sub;
    logic [HOLD_W-1:0]     frames_ext;
    logic                  out_free;

    assign out_free       = ~out_valid_reg | out_ready;
    assign out_valid      = out_valid_reg;
    assign envelope_level = env_out_reg;
    assign rms_level      = rms_out_reg;
    assign left_peak      = left_out_reg;
    assign right_peak     = right_out_reg;
    assign held_peak      = held_out_reg;
    assign clip_seen      = clip_out_reg;

    always_comb
    begin
        div_shift  = {rem_reg, dq_reg[SUM_W-1]};
        div_ge     = (div_shift >= {1'b0, div_cnt_reg});
        sq_cand    = {srem_reg, rad_reg[SQ_W-1:SQ_W-2]};
        sq_trial   = {1'b0, root_reg, 2'b01};
        sq_ge      = (sq_cand >= sq_trial);
        env_step   = eprod_reg[COEF_W+MAG_W-1:COEF_W];
        decayed    = dprod_reg[COEF_W+MAG_W-1:COEF_W];
        frames_ext = HOLD_W'(summ_reg.frames);
        timer_sub  = (timer_reg > frames_ext) ? (timer_reg - frames_ext) : '0;

        state_next     = state_reg;
        summ_next      = summ_reg;
        dq_next        = dq_reg;
        div_cnt_next   = div_cnt_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        eprod_next     = eprod_reg;
        dprod_next     = dprod_reg;
        up_next        = (summ_reg.peak > envelope_reg);
        envelope_next  = envelope_reg;
        hold_next      = hold_reg;
        timer_next     = timer_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        env_out_next   = env_out_reg;
        rms_out_next   = rms_out_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        held_out_next  = held_out_reg;
        clip_out_next  = clip_out_reg;
        q_pop          = 1'b0;
        coef           = up_next ? cfg.attack_coef : cfg.release_coef;
        if (coef > COEF_ONE)
        begin
            coef = COEF_ONE;
        end
        diff = up_next ? (summ_reg.peak - envelope_reg) : (envelope_reg - summ_reg.peak);

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    summ_next    = q_summary;
                    dq_next      = q_sum;
                    div_cnt_next = q_count;
                    rem_next     = '0;
                    step_next    = STEP_W'(SUM_W - 1);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? CNT_W'(div_shift - {1'b0, div_cnt_reg}) : div_shift[CNT_W-1:0];
                dq_next  = {dq_reg[SUM_W-2:0], div_ge};
                if (step_reg == '0)
                begin
                    rad_next   = dq_next[SQ_W-1:0];
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(MAG_W - 1);
                    state_next = ST_SQRT;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_SQRT:
            begin
                rad_next  = {rad_reg[SQ_W-3:0], 2'b00};
                srem_next = sq_ge ? (MAG_W+1)'(sq_cand - sq_trial) : sq_cand[MAG_W:0];
                root_next = {root_reg[MAG_W-2:0], sq_ge};
                if (step_reg == '0)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_MUL:
            begin
                eprod_next = EPROD_W'(diff) * EPROD_W'(coef);
                dprod_next = DPROD_W'(hold_reg) * DPROD_W'(DECAY_Q16);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    envelope_next = up_reg ? (envelope_reg + env_step) : (envelope_reg - env_step);
                    if (summ_reg.peak >= hold_reg)
                    begin
                        hold_next  = summ_reg.peak;
                        timer_next = cfg.hold_frames;
                    end
                    else
                    begin
                        timer_next = timer_sub;
                        if (timer_sub == '0)
                        begin
                            hold_next = (summ_reg.peak > decayed) ? summ_reg.peak : decayed;
                        end
                    end
                    env_out_next   = envelope_next;
                    rms_out_next   = root_reg;
                    left_out_next  = summ_reg.left;
                    right_out_next = summ_reg.right;
                    held_out_next  = hold_next;
                    clip_out_next  = summ_reg.clip;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            summ_reg      <= '0;
            dq_reg        <= '0;
            div_cnt_reg   <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            rad_reg       <= '0;
            srem_reg      <= '0;
            root_reg      <= '0;
            eprod_reg     <= '0;
            dprod_reg     <= '0;
            up_reg        <= 1'b0;
            envelope_reg  <= '0;
            hold_reg      <= '0;
            timer_reg     <= '0;
            out_valid_reg <= 1'b0;
            env_out_reg   <= '0;
            rms_out_reg   <= '0;
            left_out_reg  <= '0;
            right_out_reg <= '0;
            held_out_reg  <= '0;
            clip_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            summ_reg      <= summ_next;
            dq_reg        <= dq_next;
            div_cnt_reg   <= div_cnt_next;
            rem_reg       <= rem_next;
            step_reg      <= step_next;
            rad_reg       <= rad_next;
            srem_reg      <= srem_next;
            root_reg      <= root_next;
            eprod_reg     <= eprod_next;
            dprod_reg     <= dprod_next;
            up_reg        <= up_next;
            envelope_reg  <= envelope_next;
            hold_reg      <= hold_next;
            timer_reg     <= timer_next;
            out_valid_reg <= out_valid_next;
            env_out_reg   <= env_out_next;
            rms_out_reg   <= rms_out_next;
            left_out_reg  <= left_out_next;
            right_out_reg <= right_out_next;
            held_out_reg  <= held_out_next;
            clip_out_reg  <= clip_out_next;
        end
    end

    `ALM_ASSERT_NOW(a_pop_only_idle, q_pop, state_reg == ST_IDLE, "queue popped while busy")
    `ALM_ASSERT_NOW(a_div_rem_bound, state_reg == ST_DIV, rem_reg < div_cnt_reg, "divide remainder out of range")
    `ALM_ASSERT_NEXT(a_emit_valid, (state_reg == ST_EMIT) && out_free, out_valid_reg && (state_reg == ST_IDLE), "result word not presented")
    `ALM_ASSERT_NOW(a_env_no_overshoot, (state_reg == ST_EMIT) && out_free && up_reg, envelope_next <= summ_reg.peak, "envelope overshoots block peak")

endmodule

### sv/audio_level_meter_core.sv
// Audio level meter top level: configuration registers, front end, queue, back end.
// A result word follows its block through the queue and the back end's serial states.
// Throughput: one sample per cycle; the back end's serial divide and root handle one
// block at a time, and the two-entry queue stalls input once both entries fill.
// Reset: asynchronous active low; clears block state, envelope, hold, clip flag and
// loads configuration defaults. No clearing pass.
`timescale 1ns / 1ps

module audio_level_meter_core #(
    parameter int MAX_BLOCK_SAMPLES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [23:0] sample,
    input  logic               last_of_block,
    input  logic               in_valid,
    output logic               in_ready,
    output logic [22:0]        envelope_level,
    output logic [22:0]        rms_level,
    output logic [22:0]        left_peak,
    output logic [22:0]        right_peak,
    output logic [22:0]        held_peak,
    output logic               clip_seen,
    output logic               out_valid,
    input  logic               out_ready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [22:0]        cfg_data
);
    import alm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int SUM_W  = SQ_W + CNT_W;
    localparam int WORD_W = $bits(alm_summary_t) + SUM_W + CNT_W;

    alm_cfg_t     cfg_reg, cfg_next;
    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_not_empty;
    alm_summary_t push_summary;
    alm_summary_t pop_summary;
    logic [SUM_W-1:0]  push_sum, pop_sum;
    logic [CNT_W-1:0]  push_count, pop_count;
    logic [WORD_W-1:0] pop_word;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT:  cfg_next.channel_count  = cfg_data[CH_W-1:0];
                REG_CLIP_THRESHOLD: cfg_next.clip_threshold = cfg_data[MAG_W-1:0];
                REG_ATTACK_COEF:    cfg_next.attack_coef    = cfg_data[CFG_COEF_W-1:0];
                REG_RELEASE_COEF:   cfg_next.release_coef   = cfg_data[CFG_COEF_W-1:0];
                REG_HOLD_FRAMES:    cfg_next.hold_frames    = cfg_data[HOLD_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count  <= 4'd2;
            cfg_reg.clip_threshold <= MAG_MAX;
            cfg_reg.attack_coef    <= COEF_ONE;
            cfg_reg.release_coef   <= 17'd6554;
            cfg_reg.hold_frames    <= 20'd72000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    alm_front #(
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
        .CNT_W             (CNT_W),
        .SUM_W             (SUM_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .sample        (sample),
        .last_of_block (last_of_block),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_summary     (push_summary),
        .q_sum         (push_sum),
        .q_count       (push_count)
    );

    alm_queue #(
        .WIDTH (WORD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_summary, push_sum, push_count}),
        .pop       (q_pop),
        .pop_data  (pop_word),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    assign {pop_summary, pop_sum, pop_count} = pop_word;

    alm_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_not_empty),
        .q_summary      (pop_summary),
        .q_sum          (pop_sum),
        .q_count        (pop_count),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .envelope_level (envelope_level),
        .rms_level      (rms_level),
        .left_peak      (left_peak),
        .right_peak     (right_peak),
        .held_peak      (held_peak),
        .clip_seen      (clip_seen)
    );

endmodule
